FILE: rtl/bvm_pkg.sv
// Shared types and constants for the bytecode execute unit.
// Holds the opcode codes and the sequencer state type; no dependencies.
package bvm_pkg;

    // Opcodes of one instruction word
    localparam logic [3:0] OP_SET = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_MUL = 4'd3;
    localparam logic [3:0] OP_DIV = 4'd4;
    localparam logic [3:0] OP_MOD = 4'd5;
    localparam logic [3:0] OP_CMP = 4'd6;
    localparam logic [3:0] OP_JIF = 4'd7;
    localparam logic [3:0] OP_JMP = 4'd8;
    localparam logic [3:0] OP_RET = 4'd9;

    // Width of data words and of the restoring divider step counter
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_ABSB  = 6'b001000,
        S_DIV   = 6'b010000,
        S_SIGN  = 6'b100000
    } t_state;

endpackage

FILE: rtl/bvm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the variable store of the execute unit.
module bvm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry and register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bytecode_vm_execute_unit_top.sv
// Bytecode execute unit: runs one instruction word against a variable store.
// Depends on bvm_pkg (opcodes, state type) and bvm_ram (variable store).
//
//  channel | direction | handshake                  | payload
//  req     | in        | i_req_valid / o_req_ready  | type, dest, src, imm, jump target
//  rsp     | out       | o_rsp_valid / i_rsp_ready  | next pc, halted, return value, fault
//
// Most instructions are accepted with the store read, then commit.
// Div and mod take the magnitude of each operand, run 32 restoring steps on
// the shared adder, then a sign fix; mul uses its own multiplier, not the adder.
// After reset a clearing pass writes zero to all NUM_VARS entries, one entry a
// cycle, and no word is accepted meanwhile.
// Commit waits while the previous response word is not taken.
module bytecode_vm_execute_unit_top #(
    parameter int unsigned NUM_VARS = 256,
    parameter int unsigned PC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [3:0]  i_req_type,
    input  logic [7:0]  i_dest_slot,
    input  logic [7:0]  i_src_slot,
    input  logic signed [31:0] i_imm_value,
    input  logic [15:0] i_jump_target,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [15:0] o_next_pc,
    output logic        o_halted,
    output logic signed [31:0] o_return_value,
    output logic        o_div_fault
);

    localparam int unsigned VAR_AW = $clog2(NUM_VARS);
    localparam int unsigned DW     = bvm_pkg::DATA_W;
    localparam int unsigned CW     = bvm_pkg::CNT_W;

    // Wrap an 8-bit slot number into the store by restoring subtraction
    function automatic logic [VAR_AW-1:0] slot_wrap(input logic [7:0] slot);
        logic [19:0] x;
        x = 20'(slot);
        for (int k = 7; k >= 0; k--) begin
            if (x >= (20'(NUM_VARS) << k)) begin
                x = x - (20'(NUM_VARS) << k);
            end
        end
        return VAR_AW'(x);
    endfunction

    bvm_pkg::t_state r_state, n_state;

    logic [3:0]         r_op;
    logic [VAR_AW-1:0]  r_dst;
    logic [VAR_AW-1:0]  r_rd_addr;
    logic [DW-1:0]      r_imm;
    logic [PC_BITS-1:0] r_tgt;
    logic [PC_BITS-1:0] r_pc;
    logic               r_flag;
    logic               r_halt;
    logic [VAR_AW-1:0]  r_clr_addr;
    logic [DW-1:0]      r_quo;
    logic [DW-1:0]      r_rem;
    logic [DW-1:0]      r_dvs;
    logic [CW-1:0]      r_cnt;
    logic               r_a_neg;

    logic               r_out_valid;
    logic [15:0]        r_out_pc;
    logic               r_out_halted;
    logic [DW-1:0]      r_out_ret;
    logic               r_out_fault;

    logic               w_accept;
    logic               w_out_free;
    logic [VAR_AW-1:0]  w_in_rd;
    logic [VAR_AW-1:0]  w_raddr;
    logic [DW-1:0]      w_rdata;
    logic               w_ram_we;
    logic [VAR_AW-1:0]  w_waddr;
    logic [DW-1:0]      w_wdata;
    logic [DW-1:0]      w_mul;
    logic [PC_BITS-1:0] w_pc_inc;
    logic [DW-1:0]      w_rem_sh;
    logic               w_b_neg;

    logic [DW-1:0]      w_add_x;
    logic [DW-1:0]      w_add_y;
    logic               w_add_cin;
    logic [DW-1:0]      w_add_sum;
    logic               w_add_cout;

    logic               w_done;
    logic               w_div_start;
    logic               w_commit;
    logic               w_wr;
    logic [DW-1:0]      w_res;
    logic [PC_BITS-1:0] w_next;
    logic               w_fault;
    logic [DW-1:0]      w_ret;
    logic               w_flag_n;
    logic               w_halt_n;

    // Handshake
    assign o_req_ready = (r_state == bvm_pkg::S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_out_free  = !r_out_valid || i_rsp_ready;

    // Pick the slot to read: cmp and return read the destination
    assign w_in_rd = (i_req_type == bvm_pkg::OP_CMP || i_req_type == bvm_pkg::OP_RET)
                   ? slot_wrap(i_dest_slot) : slot_wrap(i_src_slot);
    assign w_raddr = (r_state == bvm_pkg::S_IDLE) ? w_in_rd : r_rd_addr;

    assign w_mul    = w_rdata * r_imm;
    assign w_pc_inc = r_pc + PC_BITS'(1);
    assign w_rem_sh = {r_rem[DW-2:0], r_quo[DW-1]};
    assign w_b_neg  = r_imm[DW-1];

    // Route operands into the shared adder
    always_comb begin
        logic          neg;
        logic [DW-1:0] val;
        w_add_x   = '0;
        w_add_y   = '0;
        w_add_cin = 1'b0;
        neg       = 1'b0;
        val       = '0;
        unique case (r_state)
            bvm_pkg::S_EXEC: begin
                case (r_op) inside
                    bvm_pkg::OP_ADD: begin
                        w_add_x = w_rdata;
                        w_add_y = r_imm;
                    end
                    bvm_pkg::OP_SUB, bvm_pkg::OP_CMP: begin
                        w_add_x   = w_rdata;
                        w_add_y   = ~r_imm;
                        w_add_cin = 1'b1;
                    end
                    bvm_pkg::OP_DIV, bvm_pkg::OP_MOD: begin
                        neg = w_rdata[DW-1];
                        val = w_rdata;
                    end
                    default: begin
                    end
                endcase
            end
            bvm_pkg::S_ABSB: begin
                neg = w_b_neg;
                val = r_imm;
            end
            bvm_pkg::S_DIV: begin
                w_add_x   = w_rem_sh;
                w_add_y   = ~r_dvs;
                w_add_cin = 1'b1;
            end
            bvm_pkg::S_SIGN: begin
                neg = (r_op == bvm_pkg::OP_DIV) ? (r_a_neg ^ w_b_neg) : r_a_neg;
                val = (r_op == bvm_pkg::OP_DIV) ? r_quo : r_rem;
            end
            default: begin
            end
        endcase
        // Conditional negate for magnitude and sign fix
        if (r_state == bvm_pkg::S_ABSB || r_state == bvm_pkg::S_SIGN
            || (r_state == bvm_pkg::S_EXEC
                && (r_op == bvm_pkg::OP_DIV || r_op == bvm_pkg::OP_MOD))) begin
            w_add_x   = neg ? '0 : val;
            w_add_y   = neg ? ~val : '0;
            w_add_cin = neg;
        end
    end

    assign {w_add_cout, w_add_sum} = {1'b0, w_add_x} + {1'b0, w_add_y} + (DW + 1)'(w_add_cin);

    // Work out the effect of the instruction being committed
    always_comb begin
        w_done      = 1'b0;
        w_div_start = 1'b0;
        w_wr        = 1'b0;
        w_res       = r_imm;
        w_next      = w_pc_inc;
        w_fault     = 1'b0;
        w_ret       = '0;
        w_flag_n    = r_flag;
        w_halt_n    = r_halt;
        if (r_state == bvm_pkg::S_EXEC) begin
            w_done = 1'b1;
            if (r_halt) begin
                w_next = r_pc;
            end else begin
                case (r_op) inside
                    bvm_pkg::OP_SET: begin
                        w_wr = 1'b1;
                    end
                    bvm_pkg::OP_ADD, bvm_pkg::OP_SUB: begin
                        w_wr  = 1'b1;
                        w_res = w_add_sum;
                    end
                    bvm_pkg::OP_MUL: begin
                        w_wr  = 1'b1;
                        w_res = w_mul;
                    end
                    bvm_pkg::OP_DIV, bvm_pkg::OP_MOD: begin
                        if (r_imm == '0) begin
                            w_fault = 1'b1;
                        end else begin
                            w_done      = 1'b0;
                            w_div_start = 1'b1;
                        end
                    end
                    bvm_pkg::OP_CMP: begin
                        w_flag_n = (w_add_sum == '0);
                    end
                    bvm_pkg::OP_JIF: begin
                        if (!r_flag) begin
                            w_next = r_tgt;
                        end
                    end
                    bvm_pkg::OP_JMP: begin
                        w_next = r_tgt;
                    end
                    bvm_pkg::OP_RET: begin
                        w_ret    = w_rdata;
                        w_halt_n = 1'b1;
                        w_next   = r_pc;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (r_state == bvm_pkg::S_SIGN) begin
            w_done = 1'b1;
            w_wr   = 1'b1;
            w_res  = w_add_sum;
        end
    end

    assign w_commit = w_done && w_out_free;

    // Store write port: clearing pass or commit
    assign w_ram_we = (r_state == bvm_pkg::S_CLEAR) || (w_commit && w_wr);
    assign w_waddr  = (r_state == bvm_pkg::S_CLEAR) ? r_clr_addr : r_dst;
    assign w_wdata  = (r_state == bvm_pkg::S_CLEAR) ? '0 : w_res;

    bvm_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_VARS)
    ) u_var_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bvm_pkg::S_CLEAR: begin
                if (r_clr_addr == VAR_AW'(NUM_VARS - 1)) begin
                    n_state = bvm_pkg::S_IDLE;
                end
            end
            bvm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = bvm_pkg::S_EXEC;
                end
            end
            bvm_pkg::S_EXEC: begin
                if (w_div_start) begin
                    n_state = bvm_pkg::S_ABSB;
                end else if (w_out_free) begin
                    n_state = bvm_pkg::S_IDLE;
                end
            end
            bvm_pkg::S_ABSB: begin
                n_state = bvm_pkg::S_DIV;
            end
            bvm_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = bvm_pkg::S_SIGN;
                end
            end
            bvm_pkg::S_SIGN: begin
                if (w_out_free) begin
                    n_state = bvm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bvm_pkg::S_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bvm_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_pc        <= '0;
            r_flag      <= 1'b0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bvm_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + VAR_AW'(1);
            end
            if (w_commit) begin
                r_pc        <= w_next;
                r_flag      <= w_flag_n;
                r_halt      <= w_halt_n;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Instruction fields, divider datapath and response word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_req_type;
            r_dst     <= slot_wrap(i_dest_slot);
            r_rd_addr <= w_in_rd;
            r_imm     <= i_imm_value;
            r_tgt     <= PC_BITS'(i_jump_target);
        end
        if (w_div_start) begin
            r_quo   <= w_add_sum;
            r_rem   <= '0;
            r_a_neg <= w_rdata[DW-1];
        end
        if (r_state == bvm_pkg::S_ABSB) begin
            r_dvs <= w_add_sum;
            r_cnt <= CW'(DW - 1);
        end
        if (r_state == bvm_pkg::S_DIV) begin
            r_quo <= {r_quo[DW-2:0], w_add_cout};
            r_rem <= w_add_cout ? w_add_sum : w_rem_sh;
            r_cnt <= r_cnt - CW'(1);
        end
        if (w_commit) begin
            r_out_pc     <= 16'(w_next);
            r_out_halted <= w_halt_n;
            r_out_ret    <= w_ret;
            r_out_fault  <= w_fault;
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_next_pc      = r_out_pc;
    assign o_halted       = r_out_halted;
    assign o_return_value = r_out_ret;
    assign o_div_fault    = r_out_fault;

`ifndef SYNTHESIS
    // Halt holds until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped without reset");

    // Last divider step hands over to the sign fix
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bvm_pkg::S_DIV && r_cnt == '0) |=> (r_state == bvm_pkg::S_SIGN))
        else $error("divider did not finish after its last step");

    // No store write once halted
    a_no_write_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && r_state != bvm_pkg::S_CLEAR) |-> !r_halt)
        else $error("variable store written after halt");

    // A fault never comes with a halted word
    a_fault_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_halted && o_div_fault))
        else $error("fault reported on a halted word");
`endif

endmodule

FILE: tb/bytecode_vm_execute_unit_checker.sv
// Response checker for the bytecode execute unit: watches both channels,
// predicts each response word and compares it. Depends on bvm_pkg opcodes.
module bytecode_vm_execute_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [3:0]  i_req_type,
    input  logic [7:0]  i_dest_slot,
    input  logic [7:0]  i_src_slot,
    input  logic [31:0] i_imm_value,
    input  logic [15:0] i_jump_target,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [15:0] i_next_pc,
    input  logic        i_halted,
    input  logic [31:0] i_return_value,
    input  logic        i_div_fault,
    output int          o_err_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        halted;
        logic [31:0] ret_val;
        logic        fault;
    } t_outcome;

    // Shadow machine state
    logic [31:0] shadow_vars [256];
    logic        shadow_flag;
    logic [15:0] shadow_pc;
    logic        shadow_halt;

    t_outcome    outcome_q [$];
    int          mismatch_total;

    // Run one instruction word on the shadow state and queue its outcome
    task automatic execute_word(input logic [3:0] op, input logic [7:0] d,
                                input logic [7:0] s, input logic [31:0] imm,
                                input logic [15:0] tgt);
        logic [31:0] src;
        logic [15:0] npc;
        longint      num;
        longint      den;
        longint      res;
        t_outcome    out;
        src = shadow_vars[s];
        npc = shadow_pc + 16'd1;
        out = '0;
        if (shadow_halt) begin
            out.next_pc = shadow_pc;
            out.halted  = 1'b1;
        end else begin
            case (op)
                bvm_pkg::OP_SET: shadow_vars[d] = imm;
                bvm_pkg::OP_ADD: shadow_vars[d] = src + imm;
                bvm_pkg::OP_SUB: shadow_vars[d] = src - imm;
                bvm_pkg::OP_MUL: shadow_vars[d] = src * imm;
                bvm_pkg::OP_DIV, bvm_pkg::OP_MOD: begin
                    if (imm == 32'd0) begin
                        out.fault = 1'b1;
                    end else begin
                        // 64-bit math keeps min / -1 from overflowing
                        num = $signed(src);
                        den = $signed(imm);
                        res = (op == bvm_pkg::OP_DIV) ? num / den : num % den;
                        shadow_vars[d] = res[31:0];
                    end
                end
                bvm_pkg::OP_CMP: shadow_flag = (shadow_vars[d] == imm);
                bvm_pkg::OP_JIF: if (!shadow_flag) npc = tgt;
                bvm_pkg::OP_JMP: npc = tgt;
                bvm_pkg::OP_RET: begin
                    out.ret_val = shadow_vars[d];
                    shadow_halt = 1'b1;
                    npc = shadow_pc;
                end
                default: ;
            endcase
            shadow_pc   = npc;
            out.next_pc = npc;
            out.halted  = shadow_halt;
        end
        outcome_q.insert(outcome_q.size(), out);
    endtask

    // Report one field that differs; return 1 on a mismatch
    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) shadow_vars[i] = '0;
            shadow_flag = 1'b0;
            shadow_pc   = '0;
            shadow_halt = 1'b0;
            outcome_q.delete();
        end else begin
            // Compare the response word first: it always belongs to an older request
            if (i_rsp_valid && i_rsp_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected response word pc %0h", $time, i_next_pc);
                    mismatch_total++;
                end else begin
                    want = outcome_q.pop_front();
                    mismatch_total += field_mismatch("next_pc", want.next_pc, i_next_pc);
                    mismatch_total += field_mismatch("halted", want.halted, i_halted);
                    mismatch_total += field_mismatch("return_value", want.ret_val,
                                                     i_return_value);
                    mismatch_total += field_mismatch("div_fault", want.fault, i_div_fault);
                end
            end
            if (i_req_valid && i_req_ready)
                execute_word(i_req_type, i_dest_slot, i_src_slot, i_imm_value,
                             i_jump_target);
        end
        o_err_count <= mismatch_total;
        o_pending   <= outcome_q.size();
    end

endmodule

FILE: tb/bytecode_vm_execute_unit_top_test.sv
// Top of the execute unit testbench: clock, reset, request stimulus, response
// back-pressure and verdict. Depends on bvm_pkg, the block and its checker.
module bytecode_vm_execute_unit_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_WORDS = 800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    logic [3:0]  i_req_type = '0;
    logic [7:0]  i_dest_slot = '0;
    logic [7:0]  i_src_slot = '0;
    logic signed [31:0] i_imm_value = '0;
    logic [15:0] i_jump_target = '0;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    logic [15:0] o_next_pc;
    logic        o_halted;
    logic signed [31:0] o_return_value;
    logic        o_div_fault;

    int          err_count;
    int          pending;
    int          idle_cycles = 0;
    logic        no_idle = 1'b0;

    always #2 i_clk = ~i_clk;

    bytecode_vm_execute_unit_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_req_type     (i_req_type),
        .i_dest_slot    (i_dest_slot),
        .i_src_slot     (i_src_slot),
        .i_imm_value    (i_imm_value),
        .i_jump_target  (i_jump_target),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_next_pc      (o_next_pc),
        .o_halted       (o_halted),
        .o_return_value (o_return_value),
        .o_div_fault    (o_div_fault)
    );

    bytecode_vm_execute_unit_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .i_req_ready    (o_req_ready),
        .i_req_type     (i_req_type),
        .i_dest_slot    (i_dest_slot),
        .i_src_slot     (i_src_slot),
        .i_imm_value    (i_imm_value),
        .i_jump_target  (i_jump_target),
        .i_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .i_next_pc      (o_next_pc),
        .i_halted       (o_halted),
        .i_return_value (o_return_value),
        .i_div_fault    (o_div_fault),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    // Throttle the response side except during the no-idle stretch
    always @(posedge i_clk) begin
        i_rsp_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 16);
    end

    // End the run when no word moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one instruction word and hold it until accepted
    task automatic send_word(input logic [3:0] op, input logic [7:0] d, input logic [7:0] s,
                             input logic [31:0] imm, input logic [15:0] tgt);
        while (!no_idle && $urandom_range(0, 99) < 16) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid   <= 1'b1;
        i_req_type    <= op;
        i_dest_slot   <= d;
        i_src_slot    <= s;
        i_imm_value   <= imm;
        i_jump_target <= tgt;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    // Favor a handful of slots so reads hit written values
    function automatic logic [7:0] pick_slot();
        return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'($signed($urandom_range(0, 32)) - 16);
            default: return $urandom;
        endcase
    endfunction

    // Any opcode but return, which would halt the unit for good
    function automatic logic [3:0] pick_noise_op();
        logic [3:0] op;
        op = 4'($urandom_range(0, 14));
        return (op >= bvm_pkg::OP_RET) ? op + 4'd1 : op;
    endfunction

    initial begin : stimulus
        int          n;
        int          r;
        int          chain;
        logic [7:0]  d;
        logic [7:0]  s;
        logic [31:0] v;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: wrap, division corners, compare and jump paths, no-ops
        send_word(bvm_pkg::OP_SET, 8'd0, 8'd255, 32'h7FFF_FFFF, 16'h0000);
        send_word(bvm_pkg::OP_ADD, 8'd1, 8'd0, 32'd1, 16'hFFFF);
        send_word(bvm_pkg::OP_SET, 8'd2, 8'd0, 32'h8000_0000, 16'h0000);
        send_word(bvm_pkg::OP_DIV, 8'd3, 8'd2, 32'hFFFF_FFFF, 16'h0000);
        send_word(bvm_pkg::OP_MOD, 8'd4, 8'd2, 32'hFFFF_FFFF, 16'h0000);
        send_word(bvm_pkg::OP_DIV, 8'd0, 8'd0, 32'd0, 16'h0000);
        send_word(bvm_pkg::OP_MOD, 8'd0, 8'd0, 32'd0, 16'h0000);
        send_word(bvm_pkg::OP_SET, 8'd7, 8'd0, 32'hFFFF_FFF9, 16'h0000);
        send_word(bvm_pkg::OP_DIV, 8'd8, 8'd7, 32'd2, 16'h0000);
        send_word(bvm_pkg::OP_MOD, 8'd9, 8'd7, 32'd2, 16'h0000);
        send_word(bvm_pkg::OP_DIV, 8'd10, 8'd0, 32'hFFFF_FFFD, 16'h0000);
        send_word(bvm_pkg::OP_SUB, 8'd11, 8'd2, 32'd1, 16'h0000);
        send_word(bvm_pkg::OP_MUL, 8'd12, 8'd0, 32'h7FFF_FFFF, 16'h0000);
        send_word(bvm_pkg::OP_SET, 8'd255, 8'd0, 32'hFFFF_FFFF, 16'h0000);
        send_word(bvm_pkg::OP_MUL, 8'd255, 8'd255, 32'h8000_0000, 16'h0000);
        send_word(bvm_pkg::OP_CMP, 8'd0, 8'd0, 32'h7FFF_FFFF, 16'h0000);
        send_word(bvm_pkg::OP_JIF, 8'd0, 8'd0, 32'd0, 16'h1234);
        send_word(bvm_pkg::OP_CMP, 8'd0, 8'd0, 32'd0, 16'h0000);
        send_word(bvm_pkg::OP_JIF, 8'd0, 8'd0, 32'd0, 16'hFFFF);
        send_word(4'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(bvm_pkg::OP_JMP, 8'd0, 8'd0, 32'd0, 16'h5A5A);
        send_word(4'd10, 8'd0, 8'd0, 32'd0, 16'h0000);

        // Random: mostly well-formed sequences with random content
        n = 0;
        while (n < RANDOM_WORDS) begin
            no_idle <= (n >= 300 && n < 420);
            if (n >= 500 && n < 504) begin
                // Hold off until every outstanding response is back
                i_req_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                d = pick_slot();
                v = pick_imm();
                send_word(bvm_pkg::OP_SET, d, 8'($urandom), v, 16'($urandom));
                send_word(bvm_pkg::OP_CMP, d, 8'($urandom),
                          $urandom_range(0, 1) ? v : v ^ (32'd1 << $urandom_range(0, 31)),
                          16'($urandom));
                send_word(bvm_pkg::OP_JIF, 8'($urandom), 8'($urandom), $urandom,
                          16'($urandom));
                n += 3;
            end else if (r < 70) begin
                chain = $urandom_range(1, 3);
                s = pick_slot();
                repeat (chain) begin
                    d = pick_slot();
                    send_word(4'($urandom_range(bvm_pkg::OP_ADD, bvm_pkg::OP_MOD)), d, s,
                              pick_imm(), 16'($urandom));
                    s = d;
                end
                n += chain;
            end else if (r < 80) begin
                send_word($urandom_range(0, 1) ? bvm_pkg::OP_JMP : bvm_pkg::OP_JIF,
                          8'($urandom), 8'($urandom), $urandom, 16'($urandom));
                n += 1;
            end else begin
                send_word(pick_noise_op(), 8'($urandom), 8'($urandom), $urandom,
                          16'($urandom));
                n += 1;
            end
        end
        no_idle <= 1'b0;

        // Return halts the unit; the words after it are ignored
        send_word(bvm_pkg::OP_RET, pick_slot(), 8'($urandom), $urandom, 16'($urandom));
        repeat (4) send_word(4'($urandom), 8'($urandom), 8'($urandom), $urandom,
                             16'($urandom));
        i_req_valid <= 1'b0;

        // Drain, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
